// ----- rtl/core/ulv_pkg.sv -----
// Shared types and constants for the UTF-16 length validator.
package ulv_pkg;

    // Counter and result widths
    localparam int COUNT_BITS_DEF = 32;
    localparam int COUNT_BITS_MIN = 8;
    localparam int COUNT_BITS_MAX = 64;
    localparam int OUT_BITS       = 32;
    localparam int BYTE_BITS      = 8;
    localparam int UNIT_BITS      = 16;

    // Byte order mark bytes
    localparam logic [BYTE_BITS-1:0] BOM_FE = 8'hFE;
    localparam logic [BYTE_BITS-1:0] BOM_FF = 8'hFF;

    // Top six bits of a surrogate unit: D800..DBFF high, DC00..DFFF low
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // Counter steps
    localparam logic [2:0] ONE_POINT  = 3'd1;
    localparam logic [2:0] UNIT_BYTES = 3'd2;
    localparam logic [2:0] PAIR_BYTES = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_TRUNCATED     = 2'd1,
        ST_UNPAIRED_HIGH = 2'd2,
        ST_LONE_LOW      = 2'd3
    } t_status;

    // One input word
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_in;
        logic                 last_byte;
    } t_item;

    // One result word
    typedef struct packed {
        t_status             status;
        logic [OUT_BITS-1:0] char_count;
        logic [OUT_BITS-1:0] byte_offset;
    } t_result;

endpackage

// ----- rtl/core/ulv_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
interface ulv_byte_if;
    logic                          valid;
    logic                          ready;
    logic [ulv_pkg::BYTE_BITS-1:0] byte_in;
    logic                          last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ulv_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [ulv_pkg::OUT_BITS-1:0] char_count;
    logic [ulv_pkg::OUT_BITS-1:0] byte_offset;

    modport source (output valid, output status, output char_count, output byte_offset,
                    input ready);
    modport sink   (input valid, input status, input char_count, input byte_offset,
                    output ready);
endinterface

// ----- rtl/core/ulv_in_reg.sv -----
// Input register stage: holds one byte word until the decode stage takes it.
module ulv_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ulv_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output ulv_pkg::t_item o_item
);

    logic           r_valid;
    ulv_pkg::t_item r_item;

    // Accept when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/core/ulv_core.sv -----
// Decode stage: byte pairing, mark detection, surrogate checks, counters and result register.
module ulv_core #(
    parameter int COUNT_BITS = ulv_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_le,
    input  logic             i_valid,
    input  ulv_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output ulv_pkg::t_result o_res
);

    localparam int EXT_BITS = ulv_pkg::COUNT_BITS_MAX;

    // Stream state
    logic                           r_phase, n_phase;
    logic                           r_start, n_start;
    logic                           r_le, n_le;
    logic [ulv_pkg::BYTE_BITS-1:0]  r_held, n_held;
    logic                           r_pend, n_pend;
    ulv_pkg::t_status               r_err, n_err;
    logic [COUNT_BITS-1:0]          r_pts, n_pts;
    logic [COUNT_BITS-1:0]          r_bytes, n_bytes;

    // Result register
    logic                           r_res_valid;
    ulv_pkg::t_result               r_res, n_res;

    logic                           mark_be, mark_le, is_mark, le_now, hi, lo;
    logic [ulv_pkg::UNIT_BITS-1:0]  unit;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                      input logic [2:0] n);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS+1)'(n);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [ulv_pkg::OUT_BITS-1:0] clip(input logic [COUNT_BITS-1:0] v);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return (e[EXT_BITS-1:ulv_pkg::OUT_BITS] != '0) ? {ulv_pkg::OUT_BITS{1'b1}}
                                                       : e[ulv_pkg::OUT_BITS-1:0];
    endfunction

    // Take a word unless it ends a stream and the result register is still full
    assign o_take      = i_valid && (!i_item.last_byte || !r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Form the code unit from the held byte and the incoming byte
    assign mark_be = (r_held == ulv_pkg::BOM_FE) && (i_item.byte_in == ulv_pkg::BOM_FF);
    assign mark_le = (r_held == ulv_pkg::BOM_FF) && (i_item.byte_in == ulv_pkg::BOM_FE);
    assign is_mark = r_start && (mark_be || mark_le);
    assign le_now  = r_start ? (mark_be ? 1'b0 : (mark_le ? 1'b1 : i_cfg_le)) : r_le;
    assign unit    = le_now ? {i_item.byte_in, r_held} : {r_held, i_item.byte_in};
    assign hi      = unit[ulv_pkg::UNIT_BITS-1 -: 6] == ulv_pkg::HI_SURR_TAG;
    assign lo      = unit[ulv_pkg::UNIT_BITS-1 -: 6] == ulv_pkg::LO_SURR_TAG;

    // Advance stream state and build the result on the last byte
    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_le    = r_le;
        n_held  = r_held;
        n_pend  = r_pend;
        n_err   = r_err;
        n_pts   = r_pts;
        n_bytes = r_bytes;
        n_res   = r_res;

        if (o_take) begin
            if (!r_phase) begin
                n_held  = i_item.byte_in;
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_start = 1'b0;
                n_le    = le_now;
                if (!is_mark && r_err == ulv_pkg::ST_OK) begin
                    if (r_pend) begin
                        if (lo) begin
                            n_pend  = 1'b0;
                            n_pts   = sat_add(r_pts, ulv_pkg::ONE_POINT);
                            n_bytes = sat_add(r_bytes, ulv_pkg::PAIR_BYTES);
                        end else begin
                            n_err = ulv_pkg::ST_UNPAIRED_HIGH;
                        end
                    end else if (hi) begin
                        n_pend = 1'b1;
                    end else if (lo) begin
                        n_err = ulv_pkg::ST_LONE_LOW;
                    end else begin
                        n_pts   = sat_add(r_pts, ulv_pkg::ONE_POINT);
                        n_bytes = sat_add(r_bytes, ulv_pkg::UNIT_BYTES);
                    end
                end
            end

            if (i_item.last_byte) begin
                // Odd length wins, then an error, then a dangling high surrogate
                if (n_phase) begin
                    n_res.status      = ulv_pkg::ST_TRUNCATED;
                    n_res.char_count  = '0;
                    n_res.byte_offset = '0;
                end else if (n_err != ulv_pkg::ST_OK) begin
                    n_res.status      = n_err;
                    n_res.char_count  = '0;
                    n_res.byte_offset = clip(n_bytes);
                end else if (n_pend) begin
                    n_res.status      = ulv_pkg::ST_TRUNCATED;
                    n_res.char_count  = '0;
                    n_res.byte_offset = clip(n_bytes);
                end else begin
                    n_res.status      = ulv_pkg::ST_OK;
                    n_res.char_count  = clip(n_pts);
                    n_res.byte_offset = clip(n_bytes);
                end
                // Drop stream state for the next stream
                n_phase = 1'b0;
                n_start = 1'b1;
                n_le    = 1'b0;
                n_held  = '0;
                n_pend  = 1'b0;
                n_err   = ulv_pkg::ST_OK;
                n_pts   = '0;
                n_bytes = '0;
            end
        end
    end

    // Hold stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_start <= 1'b1;
            r_le    <= 1'b0;
            r_held  <= '0;
            r_pend  <= 1'b0;
            r_err   <= ulv_pkg::ST_OK;
            r_pts   <= '0;
            r_bytes <= '0;
        end else begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_le    <= n_le;
            r_held  <= n_held;
            r_pend  <= n_pend;
            r_err   <= n_err;
            r_pts   <= n_pts;
            r_bytes <= n_bytes;
        end
    end

    // Result valid: set on a last byte, clear when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_take && i_item.last_byte) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// ----- rtl/core/utf16_length_validator_top.sv -----
// Top level of the UTF-16 validator and code point counter.
//
//   channel  | dir | words                     | handshake
//   ---------+-----+---------------------------+-------------
//   i_in     | in  | byte_in, last_byte        | valid/ready
//   o_out    | out | status, char_count, offset| valid/ready
//   i_cfg_*  | in  | default_little_endian     | write enable
//
// One byte word is accepted per cycle while no last byte is held back; a result
// becomes valid once its last byte has passed the input register and the decode
// logic has loaded the result register.
// Reset clears stream state, empties both registers and sets the default
// order to little-endian. A full result register stalls only a last byte;
// other bytes keep flowing.
module utf16_length_validator_top #(
    parameter int COUNT_BITS = ulv_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    ulv_byte_if.sink         i_in,
    ulv_res_if.source        o_out
);

    logic             r_cfg_le;
    ulv_pkg::t_item   in_item, stage_item;
    logic             stage_valid, take;
    ulv_pkg::t_result res;

    // Default byte order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_le <= 1'b1;
        end else if (i_cfg_we) begin
            r_cfg_le <= i_cfg_wdata;
        end
    end

    assign in_item.byte_in   = i_in.byte_in;
    assign in_item.last_byte = i_in.last_byte;

    ulv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (take),
        .o_item  (stage_item)
    );

    ulv_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_le    (r_cfg_le),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (take),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    assign o_out.status      = res.status;
    assign o_out.char_count  = res.char_count;
    assign o_out.byte_offset = res.byte_offset;

endmodule

// ----- dv/utf16_length_validator_top_test.sv -----
// Self-checking testbench for the UTF-16 length validator top level.
`timescale 1ns / 1ps

module utf16_length_validator_top_test;
    import ulv_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_BYTES   = 150;
    localparam int MAX_PRINTS    = 50;
    localparam logic [OUT_BITS-1:0] COUNT_TOP = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ulv_byte_if byte_ch ();
    ulv_res_if  res_ch ();

    utf16_length_validator_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (byte_ch.sink),
        .o_out      (res_ch.source)
    );

    // Decoder mirror: stream state, default order and results still owed
    logic                 dec_odd_byte;
    logic                 dec_at_start;
    logic                 dec_little;
    logic [BYTE_BITS-1:0] dec_held;
    logic                 dec_high_open;
    t_status              dec_error;
    logic [OUT_BITS-1:0]  dec_points;
    logic [OUT_BITS-1:0]  dec_bytes;
    logic                 default_little;
    t_result              owed_results[$];

    logic [BYTE_BITS-1:0] stream_bytes[$];
    int                   mismatch_count;
    int                   quiet_cycles;
    bit                   no_idling;
    int                   source_stall;
    int                   phase_sent;

    // Clock
    initial clk = 1'b0;
    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic logic [OUT_BITS-1:0] sat_add(input logic [OUT_BITS-1:0] c,
                                                    input int unsigned n);
        if (COUNT_TOP - c < n)
            return COUNT_TOP;
        return c + n;
    endfunction

    function automatic void clear_decoder();
        dec_odd_byte  = 1'b0;
        dec_at_start  = 1'b1;
        dec_little    = 1'b0;
        dec_held      = '0;
        dec_high_open = 1'b0;
        dec_error     = ST_OK;
        dec_points    = '0;
        dec_bytes     = '0;
    endfunction

    // Fold one code unit into the counts; the first error freezes them
    function automatic void absorb_unit(input logic [UNIT_BITS-1:0] u);
        logic is_high;
        logic is_low;
        is_high = (u[15:10] == HI_SURR_TAG);
        is_low  = (u[15:10] == LO_SURR_TAG);
        if (dec_error != ST_OK)
            return;
        if (dec_high_open) begin
            if (is_low) begin
                dec_high_open = 1'b0;
                dec_points    = sat_add(dec_points, ONE_POINT);
                dec_bytes     = sat_add(dec_bytes, PAIR_BYTES);
            end else begin
                dec_error = ST_UNPAIRED_HIGH;
            end
        end else if (is_high) begin
            dec_high_open = 1'b1;
        end else if (is_low) begin
            dec_error = ST_LONE_LOW;
        end else begin
            dec_points = sat_add(dec_points, ONE_POINT);
            dec_bytes  = sat_add(dec_bytes, UNIT_BYTES);
        end
    endfunction

    // Advance the mirror by one accepted byte word; queue a result on the last byte
    function automatic void predict_byte(input logic [BYTE_BITS-1:0] b, input logic last);
        logic    is_unit;
        t_result r;
        if (!dec_odd_byte) begin
            dec_held     = b;
            dec_odd_byte = 1'b1;
        end else begin
            is_unit      = 1'b1;
            dec_odd_byte = 1'b0;
            if (dec_at_start) begin
                dec_at_start = 1'b0;
                if (dec_held == BOM_FE && b == BOM_FF) begin
                    dec_little = 1'b0;
                    is_unit    = 1'b0;
                end else if (dec_held == BOM_FF && b == BOM_FE) begin
                    dec_little = 1'b1;
                    is_unit    = 1'b0;
                end else begin
                    dec_little = default_little;
                end
            end
            if (is_unit)
                absorb_unit(dec_little ? {b, dec_held} : {dec_held, b});
        end
        if (!last)
            return;
        r.char_count  = '0;
        r.byte_offset = dec_bytes;
        if (dec_odd_byte) begin
            r.status      = ST_TRUNCATED;
            r.byte_offset = '0;
        end else if (dec_error != ST_OK) begin
            r.status = dec_error;
        end else if (dec_high_open) begin
            r.status = ST_TRUNCATED;
        end else begin
            r.status     = ST_OK;
            r.char_count = dec_points;
        end
        owed_results.push_back(r);
        clear_decoder();
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] ERROR %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Result sink: random stall bursts unless idling is off
    always @(negedge clk) begin
        if (source_stall > 0) begin
            res_ch.ready = 1'b0;
            source_stall--;
        end else begin
            res_ch.ready = 1'b1;
            if (!no_idling && $urandom_range(0, 9) == 0)
                source_stall = $urandom_range(1, 9);
        end
    end

    // Compare each accepted result word with the oldest one owed
    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d count=%0d offset=%0d",
                                          res_ch.status, res_ch.char_count,
                                          res_ch.byte_offset));
            end else begin
                want = owed_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              res_ch.status, want.status));
                if (res_ch.char_count !== want.char_count)
                    report_mismatch($sformatf("char_count got %0d want %0d",
                                              res_ch.char_count, want.char_count));
                if (res_ch.byte_offset !== want.byte_offset)
                    report_mismatch($sformatf("byte_offset got %0d want %0d",
                                              res_ch.byte_offset, want.byte_offset));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] ERROR watchdog: no progress", $realtime);
            $display("utf16_length_validator_top: mismatch");
            $finish;
        end
    end

    // Drive one byte word, with an optional idle burst first; hold until accepted
    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
        @(negedge clk);
        if (!no_idling && $urandom_range(0, 7) == 0) begin
            byte_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.byte_in   = b;
        byte_ch.last_byte = last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        predict_byte(b, last);
        phase_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    task automatic put_unit(input logic [UNIT_BITS-1:0] u, input logic little);
        if (little) begin
            stream_bytes.push_back(u[7:0]);
            stream_bytes.push_back(u[15:8]);
        end else begin
            stream_bytes.push_back(u[15:8]);
            stream_bytes.push_back(u[7:0]);
        end
    endtask

    // Drop valid and let every owed result come back, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (owed_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_default_order(input logic little);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = little;
        @(negedge clk);
        cfg_we         = 1'b0;
        default_little = little;
    endtask

    function automatic logic [UNIT_BITS-1:0] plain_unit();
        logic [UNIT_BITS-1:0] u;
        case ($urandom_range(0, 7))
            0: u = 16'h0000;
            1: u = 16'hD7FF;
            2: u = 16'hE000;
            3: u = 16'hFFFF;
            4: u = {BOM_FE, BOM_FF};
            default: u = 16'($urandom_range(0, 16'hFFFF));
        endcase
        if (u[15:11] == HI_SURR_TAG[5:1])
            u ^= 16'h2000;
        return u;
    endfunction

    // Mostly well-formed streams with random content, some broken, some noise
    task automatic build_random_stream();
        logic little;
        int   n_units;
        int   pick;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 10)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 2))
            0: little = default_little;
            1: begin
                little = 1'b0;
                stream_bytes.push_back(BOM_FE);
                stream_bytes.push_back(BOM_FF);
            end
            default: begin
                little = 1'b1;
                stream_bytes.push_back(BOM_FF);
                stream_bytes.push_back(BOM_FE);
            end
        endcase
        n_units = $urandom_range(0, 8);
        for (int k = 0; k < n_units; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                put_unit(plain_unit(), little);
            end else if (pick < 85) begin
                put_unit({HI_SURR_TAG, 10'($urandom_range(0, 1023))}, little);
                put_unit({LO_SURR_TAG, 10'($urandom_range(0, 1023))}, little);
            end else if (pick < 90) begin
                put_unit({LO_SURR_TAG, 10'($urandom_range(0, 1023))}, little);
            end else if (pick < 95) begin
                put_unit({HI_SURR_TAG, 10'($urandom_range(0, 1023))}, little);
                put_unit(plain_unit(), little);
            end else begin
                put_unit({HI_SURR_TAG, 10'($urandom_range(0, 1023))}, little);
                break;
            end
        end
        if (stream_bytes.size() == 0 || $urandom_range(0, 99) < 8)
            stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Directed cases
    task automatic test_single_byte();
        stream_bytes = '{8'hFF};
        send_stream();
    endtask

    task automatic test_mark_only();
        stream_bytes = '{BOM_FE, BOM_FF};
        send_stream();
    endtask

    task automatic test_little_mark_pair();
        stream_bytes = '{BOM_FF, BOM_FE, 8'h41, 8'h00, 8'h3D, 8'hD8, 8'h00, 8'hDC};
        send_stream();
    endtask

    task automatic test_unpaired_high();
        stream_bytes = '{BOM_FE, BOM_FF, 8'hD8, 8'h00, 8'h00, 8'h41};
        send_stream();
    endtask

    task automatic test_lone_low();
        stream_bytes = '{8'h00, 8'hDC};
        send_stream();
    endtask

    task automatic test_high_at_end();
        stream_bytes = '{8'h00, 8'hD8};
        send_stream();
    endtask

    task automatic test_bytes_after_error();
        wait_idle();
        write_default_order(1'b0);
        stream_bytes = '{8'hDC, 8'h00, 8'hFF, 8'hFF, 8'h00};
        send_stream();
    endtask

    task automatic test_random_streams();
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: write_default_order(1'b1);
                1: write_default_order(1'b0);
                default: write_default_order(1'($urandom_range(0, 1)));
            endcase
            no_idling  = (p == 3);
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                build_random_stream();
                send_stream();
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = '0;
        byte_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b1;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        no_idling         = 1'b0;
        source_stall      = 0;
        phase_sent        = 0;
        default_little    = 1'b1;
        clear_decoder();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_single_byte();
        test_mark_only();
        test_little_mark_pair();
        test_unpaired_high();
        test_lone_low();
        test_high_at_end();
        test_bytes_after_error();
        test_random_streams();

        // Drain and check that nothing extra shows up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("utf16_length_validator_top: match");
        else
            $display("utf16_length_validator_top: mismatch");
        $finish;
    end

endmodule

// ----- utf16_length_validator_top.f -----
rtl/core/ulv_pkg.sv
rtl/core/ulv_if.sv
rtl/core/ulv_in_reg.sv
rtl/core/ulv_core.sv
rtl/core/utf16_length_validator_top.sv
dv/utf16_length_validator_top_test.sv
